### rtl/class_file_structure_walker_unit_assert.svh
`ifndef CLASS_FILE_STRUCTURE_WALKER_UNIT_ASSERT_SVH
`define CLASS_FILE_STRUCTURE_WALKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CFSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CFSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cfsw_pkg.sv
`timescale 1ns / 1ps

package cfsw_pkg;

  localparam int OFFSET_BITS = 32;

  localparam logic [4:0] PH_MAGIC    = 5'd0;
  localparam logic [4:0] PH_MINOR    = 5'd1;
  localparam logic [4:0] PH_MAJOR    = 5'd2;
  localparam logic [4:0] PH_PCOUNT   = 5'd3;
  localparam logic [4:0] PH_TAG      = 5'd4;
  localparam logic [4:0] PH_ULEN     = 5'd5;
  localparam logic [4:0] PH_PSKIP    = 5'd6;
  localparam logic [4:0] PH_CLSHEAD  = 5'd7;
  localparam logic [4:0] PH_ICOUNT   = 5'd8;
  localparam logic [4:0] PH_ISKIP    = 5'd9;
  localparam logic [4:0] PH_F_COUNT  = 5'd10;
  localparam logic [4:0] PH_M_COUNT  = 5'd15;
  localparam logic [4:0] PH_A_COUNT  = 5'd20;
  localparam logic [4:0] PH_A_ACOUNT = 5'd22;
  localparam logic [4:0] PH_A_ANAME  = 5'd23;
  localparam logic [4:0] PH_A_ASKIP  = 5'd24;
  localparam logic [4:0] PH_DONE     = 5'd25;
  localparam logic [4:0] PH_STOP     = 5'd26;

  localparam logic [4:0] SUB_COUNT  = 5'd0;
  localparam logic [4:0] SUB_HEAD   = 5'd1;
  localparam logic [4:0] SUB_ACOUNT = 5'd2;
  localparam logic [4:0] SUB_ANAME  = 5'd3;
  localparam logic [4:0] SUB_ASKIP  = 5'd4;

  localparam logic [1:0] GR_FIELD  = 2'd0;
  localparam logic [1:0] GR_METHOD = 2'd1;
  localparam logic [1:0] GR_CLASS  = 2'd2;

  localparam logic [1:0] EV_ENTRY    = 2'd0;
  localparam logic [1:0] EV_COMPLETE = 2'd1;
  localparam logic [1:0] EV_UNKNOWN  = 2'd2;
  localparam logic [1:0] EV_TRUNC    = 2'd3;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;
  localparam logic [15:0] BODY_UTF8  = 16'hFFFF;

  typedef struct packed {
    logic [4:0]             phase;
    logic [31:0]            gather;
    logic [2:0]             gather_count;
    logic [15:0]            pool_left;
    logic [15:0]            list_left;
    logic [15:0]            attr_left;
    logic [31:0]            skip_left;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [15:0]            slot_number;
    logic                   magic_flag;
    logic [15:0]            major_held;
  } state_t;

  // PH_MAGIC is the all-zero code
  localparam state_t STATE_RESET = '0;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  entry_tag;
    logic [15:0] entry_slot;
    logic [31:0] entry_offset;
    logic [31:0] total_size;
    logic        magic_good;
    logic [15:0] major_ver;
  } result_t;

  function automatic logic [15:0] tag_body(input logic [7:0] tag);
    logic [15:0] r;
    case (tag)
      8'd1: r = BODY_UTF8;
      8'd3, 8'd4: r = 16'd4;
      8'd5, 8'd6: r = 16'd8;
      8'd7, 8'd8, 8'd16, 8'd19, 8'd20: r = 16'd2;
      8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: r = 16'd4;
      8'd15: r = 16'd3;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

### rtl/class_file_structure_walker_unit.sv
// A byte on s_* is held in the input stage; its event is registered for m_*.
// Throughput: one byte per cycle while m_* takes results; one state pass per byte.
// A waiting result stalls the walk: the input stage holds one byte, then s_tready drops.
// Reset: synchronous rst empties both stages and returns the walk to the magic header.
`timescale 1ns / 1ps
`include "class_file_structure_walker_unit_assert.svh"

module class_file_structure_walker_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_tuser,   // [0] first_byte
  input  logic         s_tlast,   // final_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [7:0] entry_tag, [23:8] entry_slot,
                                  // [55:24] entry_offset, [87:56] total_size,
                                  // [88] magic_good, [104:89] major_ver, rest zero
  output logic [1:0]   m_tuser    // [1:0] event_kind
);
  import cfsw_pkg::*;

  logic    in_valid;
  logic    [7:0] in_byte;
  logic    in_first;
  logic    in_final;
  state_t  st;
  state_t  st_next;
  logic    ev_valid;
  result_t ev;
  logic    out_valid;
  result_t out_res;
  logic    advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  cfsw_step u_step (
    .st         (st),
    .data_byte  (in_byte),
    .first_byte (in_first),
    .final_byte (in_final),
    .st_next    (st_next),
    .ev_valid   (ev_valid),
    .ev         (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) st <= st_next;
      if (advance && ev_valid) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
      in_final <= s_tlast;
    end
    if (advance && ev_valid) out_res <= ev;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.event_kind;
  assign m_tdata  = {7'd0, out_res.major_ver, out_res.magic_good, out_res.total_size,
                     out_res.entry_offset, out_res.entry_slot, out_res.entry_tag};

  `CFSW_ASSERT_NOW(a_gather_bound, 1'b1, st.gather_count <= 3'd6, "gather count overrun")
  `CFSW_ASSERT_NOW(a_size_only_done, out_valid && out_res.event_kind != EV_COMPLETE, out_res.total_size == 32'd0, "size on non-complete event")
  `CFSW_ASSERT_NEXT(a_event_loaded, advance && ev_valid, out_valid, "event lost")
  `CFSW_ASSERT_NEXT(a_end_holds, (st.phase == PH_DONE || st.phase == PH_STOP) && !(advance && in_first), st.phase == $past(st.phase), "walk left end without restart")

endmodule

### rtl/cfsw_step.sv
`timescale 1ns / 1ps

module cfsw_step (
  input  cfsw_pkg::state_t  st,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              final_byte,
  output cfsw_pkg::state_t  st_next,
  output logic              ev_valid,
  output cfsw_pkg::result_t ev
);
  import cfsw_pkg::*;

  function automatic state_t enter_gather(input state_t s, input logic [4:0] ph);
    state_t r;
    r = s;
    r.phase = ph;
    r.gather = '0;
    r.gather_count = '0;
    return r;
  endfunction

  function automatic state_t enter_skip(input state_t s, input logic [4:0] ph,
                                        input logic [31:0] n);
    state_t r;
    r = s;
    r.phase = ph;
    r.skip_left = n;
    return r;
  endfunction

  function automatic state_t pool_next(input state_t s);
    return (s.pool_left == 16'd0) ? enter_skip(s, PH_CLSHEAD, 32'd6)
                                  : enter_gather(s, PH_TAG);
  endfunction

  function automatic logic [4:0] group_base(input logic [1:0] g);
    logic [4:0] r;
    case (g)
      GR_FIELD:  r = PH_F_COUNT;
      GR_METHOD: r = PH_M_COUNT;
      default:   r = PH_A_COUNT;
    endcase
    return r;
  endfunction

  function automatic state_t rec_next(input state_t s, input logic [1:0] g);
    state_t r;
    r = s;
    if (s.list_left == 16'd0) begin
      if (g == GR_FIELD) r = enter_gather(s, PH_M_COUNT);
      else r = enter_gather(s, PH_A_ACOUNT);
    end else begin
      r.list_left = s.list_left - 16'd1;
      r = enter_skip(r, group_base(g) + SUB_HEAD, 32'd6);
    end
    return r;
  endfunction

  function automatic state_t attr_next(input state_t s, input logic [1:0] g);
    state_t r;
    r = s;
    if (s.attr_left == 16'd0) begin
      if (g == GR_CLASS) r.phase = PH_DONE;
      else r = rec_next(s, g);
    end else begin
      r.attr_left = s.attr_left - 16'd1;
      r = enter_gather(r, group_base(g) + SUB_ANAME);
    end
    return r;
  endfunction

  state_t      cur;
  state_t      nx;
  logic        idle;
  logic [31:0] g_new;
  logic [2:0]  gc_new;
  logic [15:0] n16;
  logic [31:0] skip_dec;
  logic        skip_done;
  logic [15:0] body;
  logic [15:0] use_cnt;
  logic [1:0]  grp;
  logic [4:0]  sub;
  logic        tag_known;
  logic        tag_unknown;

  always_comb begin
    cur = first_byte ? STATE_RESET : st;
    nx = cur;
    g_new = {cur.gather[23:0], data_byte};
    gc_new = cur.gather_count + 3'd1;
    n16 = g_new[15:0];
    skip_dec = (cur.skip_left != 32'd0) ? cur.skip_left - 32'd1 : 32'd0;
    skip_done = (skip_dec == 32'd0);
    body = tag_body(data_byte);
    use_cnt = (data_byte == 8'd5 || data_byte == 8'd6) ? 16'd2 : 16'd1;
    tag_known = 1'b0;
    tag_unknown = 1'b0;
    idle = cur.phase >= PH_A_COUNT && cur.phase != PH_A_ACOUNT &&
           cur.phase != PH_A_ANAME && cur.phase != PH_A_ASKIP;
    if (cur.phase >= PH_A_COUNT) begin
      grp = GR_CLASS;
      sub = cur.phase - PH_A_COUNT;
    end else if (cur.phase >= PH_M_COUNT) begin
      grp = GR_METHOD;
      sub = cur.phase - PH_M_COUNT;
    end else begin
      grp = GR_FIELD;
      sub = cur.phase - PH_F_COUNT;
    end

    if (!idle) begin
      nx.gather = g_new;
      nx.gather_count = gc_new;
      case (cur.phase)
        PH_MAGIC: begin
          if (gc_new >= 3'd4) begin
            nx.magic_flag = (g_new == MAGIC_WORD);
            nx = enter_gather(nx, PH_MINOR);
          end
        end
        PH_MINOR: begin
          if (gc_new >= 3'd2) nx = enter_gather(nx, PH_MAJOR);
        end
        PH_MAJOR: begin
          if (gc_new >= 3'd2) begin
            nx.major_held = n16;
            nx = enter_gather(nx, PH_PCOUNT);
          end
        end
        PH_PCOUNT: begin
          if (gc_new >= 3'd2) begin
            nx.pool_left = (n16 != 16'd0) ? n16 - 16'd1 : 16'd0;
            nx.slot_number = 16'd1;
            nx = pool_next(nx);
          end
        end
        PH_TAG: begin
          nx.gather = cur.gather;
          nx.gather_count = cur.gather_count;
          if (body == 16'd0) begin
            tag_unknown = 1'b1;
            nx.phase = PH_STOP;
          end else begin
            tag_known = 1'b1;
            nx.pool_left = (cur.pool_left > use_cnt) ? cur.pool_left - use_cnt : 16'd0;
            nx.slot_number = cur.slot_number + use_cnt;
            if (body == BODY_UTF8) nx = enter_gather(nx, PH_ULEN);
            else nx = enter_skip(nx, PH_PSKIP, {16'd0, body});
          end
        end
        PH_ULEN: begin
          if (gc_new >= 3'd2) begin
            if (n16 == 16'd0) nx = pool_next(nx);
            else nx = enter_skip(nx, PH_PSKIP, {16'd0, n16});
          end
        end
        PH_PSKIP: begin
          nx.gather = cur.gather;
          nx.gather_count = cur.gather_count;
          nx.skip_left = skip_dec;
          if (skip_done) nx = pool_next(nx);
        end
        PH_CLSHEAD: begin
          nx.gather = cur.gather;
          nx.gather_count = cur.gather_count;
          nx.skip_left = skip_dec;
          if (skip_done) nx = enter_gather(nx, PH_ICOUNT);
        end
        PH_ICOUNT: begin
          if (gc_new >= 3'd2) begin
            if (n16 == 16'd0) nx = enter_gather(nx, PH_F_COUNT);
            else nx = enter_skip(nx, PH_ISKIP, {15'd0, n16, 1'b0});
          end
        end
        PH_ISKIP: begin
          nx.gather = cur.gather;
          nx.gather_count = cur.gather_count;
          nx.skip_left = skip_dec;
          if (skip_done) nx = enter_gather(nx, PH_F_COUNT);
        end
        default: begin
          case (sub)
            SUB_COUNT: begin
              if (gc_new >= 3'd2) begin
                nx.list_left = n16;
                nx = rec_next(nx, grp);
              end
            end
            SUB_HEAD: begin
              nx.gather = cur.gather;
              nx.gather_count = cur.gather_count;
              nx.skip_left = skip_dec;
              if (skip_done) nx = enter_gather(nx, group_base(grp) + SUB_ACOUNT);
            end
            SUB_ACOUNT: begin
              if (gc_new >= 3'd2) begin
                nx.attr_left = n16;
                nx = attr_next(nx, grp);
              end
            end
            SUB_ANAME: begin
              if (gc_new >= 3'd6) begin
                if (g_new == 32'd0) nx = attr_next(nx, grp);
                else nx = enter_skip(nx, group_base(grp) + SUB_ASKIP, g_new);
              end
            end
            default: begin
              nx.gather = cur.gather;
              nx.gather_count = cur.gather_count;
              nx.skip_left = skip_dec;
              if (skip_done) nx = attr_next(nx, grp);
            end
          endcase
        end
      endcase
      if (!(&cur.byte_offset)) nx.byte_offset = cur.byte_offset + OFFSET_BITS'(1);
    end

    ev_valid = 1'b0;
    ev.event_kind = EV_ENTRY;
    ev.entry_tag = 8'd0;
    ev.entry_slot = 16'd0;
    ev.entry_offset = 32'd0;
    ev.total_size = 32'd0;
    if (!idle) begin
      if (nx.phase == PH_DONE) begin
        ev_valid = 1'b1;
        ev.event_kind = EV_COMPLETE;
        ev.total_size = sat32(nx.byte_offset);
      end else if (tag_unknown) begin
        ev_valid = 1'b1;
        ev.event_kind = EV_UNKNOWN;
        ev.entry_tag = data_byte;
        ev.entry_slot = cur.slot_number;
        ev.entry_offset = sat32(cur.byte_offset);
      end else if (final_byte) begin
        ev_valid = 1'b1;
        ev.event_kind = EV_TRUNC;
        ev.entry_offset = sat32(nx.byte_offset);
        nx.phase = PH_STOP;
      end else if (tag_known) begin
        ev_valid = 1'b1;
        ev.event_kind = EV_ENTRY;
        ev.entry_tag = data_byte;
        ev.entry_slot = cur.slot_number;
        ev.entry_offset = sat32(cur.byte_offset);
      end
    end
    ev.magic_good = nx.magic_flag;
    ev.major_ver = nx.major_held;
    st_next = nx;
  end

endmodule
